### rtl/rdp_pkg.sv
// Shared constants, types and byte-lane helpers for the RAMDAC palette port.
package rdp_pkg;

    localparam int SEL_W  = 5;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 8;
    localparam int RGB_W  = 24;

    typedef logic [RGB_W-1:0]  t_rgb;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [1:0]        t_phase;

    // register offsets
    localparam logic [SEL_W-1:0] SEL_MAIN_WA   = 5'd0;
    localparam logic [SEL_W-1:0] SEL_MAIN_DATA = 5'd1;
    localparam logic [SEL_W-1:0] SEL_MAIN_RA   = 5'd2;
    localparam logic [SEL_W-1:0] SEL_OVL_WA    = 5'd3;
    localparam logic [SEL_W-1:0] SEL_OVL_DATA  = 5'd4;
    localparam logic [SEL_W-1:0] SEL_OVL_RA    = 5'd5;

    // color phase
    localparam t_phase PH_RED   = 2'd0;
    localparam t_phase PH_GREEN = 2'd1;
    localparam t_phase PH_BLUE  = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    function automatic t_rgb put_byte(input t_rgb trip, input t_phase ph, input t_byte b);
        t_rgb r;
        r = trip;
        case (ph)
            PH_RED:   r[23:16] = b;
            PH_GREEN: r[15:8]  = b;
            default:  r[7:0]   = b;
        endcase
        return r;
    endfunction

    function automatic t_byte get_byte(input t_rgb trip, input t_phase ph);
        t_byte b;
        case (ph)
            PH_RED:   b = trip[23:16];
            PH_GREEN: b = trip[15:8];
            default:  b = trip[7:0];
        endcase
        return b;
    endfunction

endpackage

### rtl/rdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ramdac_palette_port.sv
// RAMDAC palette port: bus access decode, palette RAMs, scratch bytes.
// Results are registered: an accepted transfer loads the result register; a palette
//   data read at the red phase first reads the palette RAM, then loads the result register.
// Throughput: one access per cycle unless a result waits; a red-phase data read stalls input.
// Reset (synchronous, active low): addresses, phases, triples, scratch bytes and the
//   per-entry valid bits clear, color mode sets to 1; entries not yet written read as 0.
module ramdac_palette_port
    import rdp_pkg::*;
#(
    parameter int MAIN_ENTRIES    = 256,
    parameter int OVERLAY_ENTRIES = 16,
    parameter int REG_SPACE       = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // color_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [4:0] reg_select, [12:5] write_data, rest 0
    input  logic        s_axis_tuser,    // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata     // [7:0] read_data
);

    localparam int MAW       = (MAIN_ENTRIES > 1) ? $clog2(MAIN_ENTRIES) : 1;
    localparam int OAW       = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 1;
    localparam int SCR_DEPTH = (REG_SPACE < 32) ? REG_SPACE : 32;
    localparam int SAW       = $clog2(SCR_DEPTH);

    // payload
    logic              in_wr;
    logic [SEL_W-1:0]  in_sel;
    t_byte             in_wd;
    logic              accept;

    assign in_wr  = s_axis_tuser;
    assign in_sel = s_axis_tdata[4:0];
    assign in_wd  = s_axis_tdata[12:5];

    // address reduction tables, folded at elaboration
    logic [MAW-1:0] main_mod [256];
    logic [OAW-1:0] ovl_mod  [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign main_mod[g] = MAW'(g % MAIN_ENTRIES);
        assign ovl_mod[g]  = OAW'(g % OVERLAY_ENTRIES);
    end

    // state
    logic                r_color_mode;
    logic [ADDR_W-1:0]   r_main_wa, n_main_wa, r_main_ra, n_main_ra;
    t_phase              r_main_ph, n_main_ph;
    t_rgb                r_main_trip, n_main_trip;
    logic [OAW-1:0]      r_ovl_wa, n_ovl_wa, r_ovl_ra, n_ovl_ra;
    t_phase              r_ovl_ph, n_ovl_ph;
    t_rgb                r_ovl_trip, n_ovl_trip;
    t_byte               r_scr [SCR_DEPTH];
    logic [MAIN_ENTRIES-1:0]    r_main_vld;
    logic [OVERLAY_ENTRIES-1:0] r_ovl_vld;
    logic                r_fetch, n_fetch;
    logic                r_fetch_ovl, n_fetch_ovl;
    logic                r_fetch_vld, n_fetch_vld;
    logic                r_out_valid, n_out_valid;
    t_byte               r_out_data, n_out_data;

    // memory ports
    logic           main_we, main_re, ovl_we, ovl_re;
    logic [MAW-1:0] main_widx, main_ridx;
    t_rgb           main_rdata, ovl_rdata, fetched;
    logic           scr_we, scr_hit;
    t_byte          rd;

    assign s_axis_tready = !r_fetch && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign main_widx = main_mod[r_main_wa];
    assign main_ridx = main_mod[r_main_ra];
    assign scr_hit   = {2'b00, in_sel} < 7'(REG_SPACE);

    assign fetched = !r_fetch_vld ? '0 : (r_fetch_ovl ? ovl_rdata : main_rdata);

    always_comb begin
        n_main_wa   = r_main_wa;
        n_main_ra   = r_main_ra;
        n_main_ph   = r_main_ph;
        n_main_trip = r_main_trip;
        n_ovl_wa    = r_ovl_wa;
        n_ovl_ra    = r_ovl_ra;
        n_ovl_ph    = r_ovl_ph;
        n_ovl_trip  = r_ovl_trip;
        n_fetch     = 1'b0;
        n_fetch_ovl = r_fetch_ovl;
        n_fetch_vld = r_fetch_vld;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        main_we     = 1'b0;
        main_re     = 1'b0;
        ovl_we      = 1'b0;
        ovl_re      = 1'b0;
        scr_we      = 1'b0;
        rd          = '0;

        if (r_fetch) begin
            // red byte of a freshly fetched entry
            n_out_valid = 1'b1;
            n_out_data  = fetched[23:16];
            if (r_fetch_ovl) begin
                n_ovl_trip = fetched;
                n_ovl_ph   = PH_GREEN;
            end else begin
                n_main_trip = fetched;
                n_main_ph   = PH_GREEN;
            end
        end else if (accept) begin
            unique case (in_sel)
                SEL_MAIN_WA: begin
                    if (in_wr == OP_WRITE) begin
                        n_main_wa = in_wd;
                        n_main_ph = PH_RED;
                    end
                end
                SEL_MAIN_RA: begin
                    if (in_wr == OP_WRITE) begin
                        n_main_ra = in_wd;
                        n_main_ph = PH_RED;
                    end
                end
                SEL_OVL_WA: begin
                    if (in_wr == OP_WRITE) begin
                        n_ovl_wa = ovl_mod[in_wd];
                        n_ovl_ph = PH_RED;
                    end
                end
                SEL_OVL_RA: begin
                    if (in_wr == OP_WRITE) begin
                        n_ovl_ra = ovl_mod[in_wd];
                        n_ovl_ph = PH_RED;
                    end
                end
                SEL_MAIN_DATA: begin
                    if (in_wr == OP_WRITE) begin
                        n_main_trip = put_byte(r_main_trip, r_main_ph, in_wd);
                        if (r_main_ph == PH_BLUE) begin
                            main_we   = r_color_mode;
                            n_main_ph = PH_RED;
                            n_main_wa = r_main_wa + 1'b1;
                        end else begin
                            n_main_ph = r_main_ph + 1'b1;
                        end
                    end else if (r_main_ph == PH_RED) begin
                        main_re     = 1'b1;
                        n_fetch     = 1'b1;
                        n_fetch_ovl = 1'b0;
                        n_fetch_vld = r_main_vld[main_ridx];
                    end else begin
                        rd = get_byte(r_main_trip, r_main_ph);
                        if (r_main_ph == PH_BLUE) begin
                            n_main_ph = PH_RED;
                            n_main_ra = r_main_ra + 1'b1;
                        end else begin
                            n_main_ph = r_main_ph + 1'b1;
                        end
                    end
                end
                SEL_OVL_DATA: begin
                    if (in_wr == OP_WRITE) begin
                        n_ovl_trip = put_byte(r_ovl_trip, r_ovl_ph, in_wd);
                        if (r_ovl_ph == PH_BLUE) begin
                            ovl_we   = r_color_mode;
                            n_ovl_ph = PH_RED;
                            n_ovl_wa = (r_ovl_wa == OAW'(OVERLAY_ENTRIES - 1)) ? '0
                                                                             : r_ovl_wa + 1'b1;
                        end else begin
                            n_ovl_ph = r_ovl_ph + 1'b1;
                        end
                    end else if (r_ovl_ph == PH_RED) begin
                        ovl_re      = 1'b1;
                        n_fetch     = 1'b1;
                        n_fetch_ovl = 1'b1;
                        n_fetch_vld = r_ovl_vld[r_ovl_ra];
                    end else begin
                        rd = get_byte(r_ovl_trip, r_ovl_ph);
                        if (r_ovl_ph == PH_BLUE) begin
                            n_ovl_ph = PH_RED;
                            n_ovl_ra = (r_ovl_ra == OAW'(OVERLAY_ENTRIES - 1)) ? '0
                                                                             : r_ovl_ra + 1'b1;
                        end else begin
                            n_ovl_ph = r_ovl_ph + 1'b1;
                        end
                    end
                end
                default: begin
                    if (scr_hit) begin
                        if (in_wr == OP_WRITE) begin
                            scr_we = 1'b1;
                        end else begin
                            rd = r_scr[in_sel[SAW-1:0]];
                        end
                    end
                end
            endcase

            if (!n_fetch) begin
                n_out_valid = 1'b1;
                n_out_data  = (in_wr == OP_WRITE) ? '0 : rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b1;
            r_main_wa    <= '0;
            r_main_ra    <= '0;
            r_main_ph    <= PH_RED;
            r_main_trip  <= '0;
            r_ovl_wa     <= '0;
            r_ovl_ra     <= '0;
            r_ovl_ph     <= PH_RED;
            r_ovl_trip   <= '0;
            r_main_vld   <= '0;
            r_ovl_vld    <= '0;
            r_fetch      <= 1'b0;
            r_fetch_ovl  <= 1'b0;
            r_fetch_vld  <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < SCR_DEPTH; i++) begin
                r_scr[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_color_mode <= i_cfg_wdata;
            end
            r_main_wa   <= n_main_wa;
            r_main_ra   <= n_main_ra;
            r_main_ph   <= n_main_ph;
            r_main_trip <= n_main_trip;
            r_ovl_wa    <= n_ovl_wa;
            r_ovl_ra    <= n_ovl_ra;
            r_ovl_ph    <= n_ovl_ph;
            r_ovl_trip  <= n_ovl_trip;
            r_fetch     <= n_fetch;
            r_fetch_ovl <= n_fetch_ovl;
            r_fetch_vld <= n_fetch_vld;
            r_out_valid <= n_out_valid;
            if (main_we) begin
                r_main_vld[main_widx] <= 1'b1;
            end
            if (ovl_we) begin
                r_ovl_vld[r_ovl_wa] <= 1'b1;
            end
            if (scr_we) begin
                r_scr[in_sel[SAW-1:0]] <= in_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    rdp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAIN_ENTRIES)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_we),
        .i_waddr (main_widx),
        .i_wdata (n_main_trip),
        .i_re    (main_re),
        .i_raddr (main_ridx),
        .o_rdata (main_rdata)
    );

    rdp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (OVERLAY_ENTRIES)
    ) u_ovl_ram (
        .i_clk   (i_clk),
        .i_we    (ovl_we),
        .i_waddr (r_ovl_wa),
        .i_wdata (n_ovl_trip),
        .i_re    (ovl_re),
        .i_raddr (r_ovl_ra),
        .o_rdata (ovl_rdata)
    );

    // a fetch never repeats back to back and always lands in the result register
    a_fetch_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch |=> !r_fetch)
        else $error("palette fetch held longer than one cycle");

    a_fetch_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch |=> m_axis_tvalid)
        else $error("palette fetch produced no result");

    a_fetch_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch |-> !s_axis_tready)
        else $error("input taken while a palette fetch is pending");

    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((main_we || ovl_we) && (main_re || ovl_re)))
        else $error("palette read and write in the same cycle");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_ph != 2'd3 && r_ovl_ph != 2'd3)
        else $error("color phase out of range");

endmodule

### sim/ramdac_palette_port_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RAMDAC palette port: directed table, then random bus accesses.
module ramdac_palette_port_tb;
    import rdp_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAIN_N       = 256;
    localparam int OVL_N        = 16;
    localparam int SCR_N        = 32;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 6;

    typedef logic [SEL_W-1:0] t_sel;

    typedef struct {
        logic  op;
        t_sel  sel;
        t_byte wd;
        logic  fixed;
        t_byte res;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [4:0] reg_select, [12:5] write_data, rest 0
    logic        s_axis_tuser  = 1'b0;  // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] read_data

    // travels with the access: expected byte fixed by the directed table
    logic  read_fixed     = 1'b0;
    t_byte read_fixed_val = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_cnt      = 0;
    int n_sent         = 0;
    int n_xfer         = 0;
    int n_results      = 0;
    int n_nonzero      = 0;
    int n_errors       = 0;
    int n_directed     = 0;

    t_byte    read_bytes_q[$];
    t_dir_row dir_rows[$];

    // shadow of the block state
    t_rgb        main_pal [MAIN_N];
    t_rgb        ovl_pal  [OVL_N];
    t_byte       scratch  [SCR_N];
    logic [7:0]  m_wa, m_ra;
    t_phase      m_ph;
    t_rgb        m_trip;
    logic [3:0]  o_wa, o_ra;
    t_phase      o_ph;
    t_rgb        o_trip;
    logic        color_mode;

    ramdac_palette_port dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycle_cnt, read_bytes_q.size());
            $display("FAIL ramdac_palette_port");
            $finish;
        end
    end

    function automatic t_byte lane_of(input t_rgb trip, input t_phase ph);
        return t_byte'(trip >> (16 - 8 * int'(ph)));
    endfunction

    function automatic t_rgb with_lane(input t_rgb trip, input t_phase ph, input t_byte b);
        int sh;
        sh = 16 - 8 * int'(ph);
        return (trip & ~(t_rgb'(8'hFF) << sh)) | (t_rgb'(b) << sh);
    endfunction

    task automatic clear_shadow();
        foreach (main_pal[i]) main_pal[i] = '0;
        foreach (ovl_pal[i]) ovl_pal[i] = '0;
        foreach (scratch[i]) scratch[i] = '0;
        m_wa = '0; m_ra = '0; m_ph = PH_RED; m_trip = '0;
        o_wa = '0; o_ra = '0; o_ph = PH_RED; o_trip = '0;
        color_mode = 1'b1;
    endtask

    // One bus access against the shadow state; returns the byte the block should give back.
    task automatic palette_access(input logic op, input t_sel sel, input t_byte wd,
                                  output t_byte rd);
        rd = '0;
        case (sel)
            SEL_MAIN_WA: if (op == OP_WRITE) begin m_wa = wd; m_ph = PH_RED; end
            SEL_MAIN_RA: if (op == OP_WRITE) begin m_ra = wd; m_ph = PH_RED; end
            SEL_OVL_WA:  if (op == OP_WRITE) begin o_wa = wd[3:0]; o_ph = PH_RED; end
            SEL_OVL_RA:  if (op == OP_WRITE) begin o_ra = wd[3:0]; o_ph = PH_RED; end
            SEL_MAIN_DATA: begin
                if (op == OP_WRITE) begin
                    m_trip = with_lane(m_trip, m_ph, wd);
                    if (m_ph == PH_BLUE) begin
                        if (color_mode) main_pal[m_wa] = m_trip;
                        m_ph = PH_RED;
                        m_wa = m_wa + 8'd1;
                    end else begin
                        m_ph = m_ph + 2'd1;
                    end
                end else begin
                    if (m_ph == PH_RED) m_trip = main_pal[m_ra];
                    rd = lane_of(m_trip, m_ph);
                    if (m_ph == PH_BLUE) begin
                        m_ph = PH_RED;
                        m_ra = m_ra + 8'd1;
                    end else begin
                        m_ph = m_ph + 2'd1;
                    end
                end
            end
            SEL_OVL_DATA: begin
                if (op == OP_WRITE) begin
                    o_trip = with_lane(o_trip, o_ph, wd);
                    if (o_ph == PH_BLUE) begin
                        if (color_mode) ovl_pal[o_wa] = o_trip;
                        o_ph = PH_RED;
                        o_wa = o_wa + 4'd1;
                    end else begin
                        o_ph = o_ph + 2'd1;
                    end
                end else begin
                    if (o_ph == PH_RED) o_trip = ovl_pal[o_ra];
                    rd = lane_of(o_trip, o_ph);
                    if (o_ph == PH_BLUE) begin
                        o_ph = PH_RED;
                        o_ra = o_ra + 4'd1;
                    end else begin
                        o_ph = o_ph + 2'd1;
                    end
                end
            end
            default: begin
                if (op == OP_WRITE) scratch[sel] = wd;
                else rd = scratch[sel];
            end
        endcase
    endtask

    // Checks results and updates the shadow on every transfer, both sampled at the edge.
    always @(posedge i_clk) begin
        t_byte rd;
        t_byte want;
        if (!i_rst_n) begin
            clear_shadow();
            read_bytes_q.delete();
        end else begin
            if (i_cfg_we) color_mode = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (m_axis_tdata != 8'd0) n_nonzero++;
                if (read_bytes_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, actual %02h",
                             $time, m_axis_tdata);
                end else begin
                    want = read_bytes_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        n_errors++;
                        $display("%0t: read_data mismatch: expected %02h, actual %02h",
                                 $time, want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                palette_access(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[12:5], rd);
                if (read_fixed) rd = read_fixed_val;
                read_bytes_q.push_back(rd);
                n_xfer++;
            end
        end
    end

    task automatic send_access(input logic op, input t_sel sel, input t_byte wd,
                               input logic fixed, input t_byte fixed_val);
        if (send_idle_pct != 0) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid  <= 1'b1;
        s_axis_tdata   <= {3'b000, wd, sel};
        s_axis_tuser   <= op;
        read_fixed     <= fixed;
        read_fixed_val <= fixed_val;
        n_sent++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic access(input logic op, input t_sel sel, input t_byte wd);
        send_access(op, sel, wd, 1'b0, '0);
    endtask

    task automatic add_row(input logic op, input t_sel sel, input t_byte wd,
                           input logic fixed, input t_byte res);
        t_dir_row r;
        r.op = op; r.sel = sel; r.wd = wd; r.fixed = fixed; r.res = res;
        dir_rows.push_back(r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (read_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_color_mode(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // half the addresses land in a small window so reads revisit written entries
    function automatic t_byte pick_addr();
        if ($urandom_range(0, 1)) return t_byte'($urandom_range(0, 7));
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic int triple_run();
        int n;
        n = 3 * $urandom_range(1, 3);
        // some runs stop short or spill into the next entry
        if ($urandom_range(0, 99) < 15) n = $urandom_range(0, 1) ? n + 1 : n - 1;
        return n;
    endfunction

    function automatic logic rand_op();
        return $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    endfunction

    task automatic random_burst();
        int   kind;
        int   n;
        t_sel s;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            repeat ($urandom_range(1, 4))
                access(rand_op(), t_sel'($urandom_range(0, SCR_N - 1)),
                       t_byte'($urandom_range(0, 255)));
        end else if (kind < 40) begin
            access(OP_WRITE, SEL_MAIN_WA, pick_addr());
            n = triple_run();
            repeat (n) access(OP_WRITE, SEL_MAIN_DATA, t_byte'($urandom_range(0, 255)));
        end else if (kind < 60) begin
            access(OP_WRITE, SEL_MAIN_RA, pick_addr());
            n = triple_run();
            repeat (n) access(OP_READ, SEL_MAIN_DATA, t_byte'($urandom_range(0, 255)));
        end else if (kind < 72) begin
            access(OP_WRITE, SEL_OVL_WA, t_byte'($urandom_range(0, 255)));
            n = triple_run();
            repeat (n) access(OP_WRITE, SEL_OVL_DATA, t_byte'($urandom_range(0, 255)));
        end else if (kind < 84) begin
            access(OP_WRITE, SEL_OVL_RA, t_byte'($urandom_range(0, 255)));
            n = triple_run();
            repeat (n) access(OP_READ, SEL_OVL_DATA, t_byte'($urandom_range(0, 255)));
        end else if (kind < 92) begin
            s = t_sel'($urandom_range(int'(SEL_OVL_RA) + 1, SCR_N - 1));
            access(OP_WRITE, s, t_byte'($urandom_range(0, 255)));
            access(OP_READ, s, t_byte'($urandom_range(0, 255)));
        end else begin
            // reads and writes of one palette mixed: shared phase and triple
            s = $urandom_range(0, 1) ? SEL_MAIN_DATA : SEL_OVL_DATA;
            repeat ($urandom_range(3, 8)) access(rand_op(), s, t_byte'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int start;
        // after reset: both palettes and the scratch bytes read as zero
        add_row(OP_READ,  SEL_MAIN_DATA, 8'h00, 1'b1, 8'h00);
        add_row(OP_READ,  SEL_OVL_DATA,  8'h00, 1'b1, 8'h00);
        add_row(OP_READ,  t_sel'(SCR_N - 1), 8'h00, 1'b1, 8'h00);
        // last main entry, extreme bytes, read back and read address wrap
        add_row(OP_WRITE, SEL_MAIN_WA,   8'hFF, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_MAIN_DATA, 8'hFF, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_MAIN_DATA, 8'h00, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_MAIN_DATA, 8'hA5, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_MAIN_RA,   8'hFF, 1'b1, 8'h00);
        add_row(OP_READ,  SEL_MAIN_DATA, 8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  SEL_MAIN_DATA, 8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  SEL_MAIN_DATA, 8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  SEL_MAIN_DATA, 8'h00, 1'b0, 8'h00);
        // address registers read as zero
        add_row(OP_READ,  SEL_MAIN_RA,   8'h00, 1'b1, 8'h00);
        add_row(OP_READ,  SEL_OVL_WA,    8'h00, 1'b1, 8'h00);
        // overlay address above 15 is masked; write address wraps after entry 15
        add_row(OP_WRITE, SEL_OVL_WA,    8'hFF, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_OVL_DATA,  8'h12, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_OVL_DATA,  8'h34, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_OVL_DATA,  8'h56, 1'b1, 8'h00);
        add_row(OP_WRITE, SEL_OVL_RA,    8'h1F, 1'b1, 8'h00);
        add_row(OP_READ,  SEL_OVL_DATA,  8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  SEL_OVL_DATA,  8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  SEL_OVL_DATA,  8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  SEL_OVL_DATA,  8'h00, 1'b0, 8'h00);
        // scratch byte, then a write and a read sharing the main phase
        add_row(OP_WRITE, t_sel'(int'(SEL_OVL_RA) + 1), 8'h80, 1'b1, 8'h00);
        add_row(OP_READ,  t_sel'(int'(SEL_OVL_RA) + 1), 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, SEL_MAIN_DATA, 8'h77, 1'b1, 8'h00);
        add_row(OP_READ,  SEL_MAIN_DATA, 8'h00, 1'b0, 8'h00);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_access(dir_rows[i].op, dir_rows[i].sel, dir_rows[i].wd,
                        dir_rows[i].fixed, dir_rows[i].res);
        n_directed = n_sent;
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_color_mode(p[0]);
            case (p >> 1)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            start = n_sent;
            while (n_sent - start < PHASE_ITEMS) random_burst();
            drain();
        end

        if (read_bytes_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, read_bytes_q.size());
        end
        $display("Ran %0d transfers (%0d directed), checked %0d results, %0d nonzero reads",
                 n_xfer, n_directed, n_results, n_nonzero);
        $display("Mono and color modes under four flow-control mixes, %0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("PASS ramdac_palette_port");
        end else begin
            $display("FAIL ramdac_palette_port");
        end
        $finish;
    end

endmodule
